[sv/ballistic_drag_euler_step_unit_defines.svh]
// Assertion macros shared by the checker of the projectile step unit.
`ifndef BALLISTIC_DRAG_EULER_STEP_UNIT_DEFINES_SVH
`define BALLISTIC_DRAG_EULER_STEP_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BDES_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BDES_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/bdes_pkg.sv]
// Types and constants of the projectile step unit.
package bdes_pkg;

   localparam int POS_W      = 40;
   localparam int VEL_W      = 32;
   localparam int DIV_W      = 48;
   localparam int DIV_CNT_W  = 6;
   localparam int SQRT_STEPS = 32;

   localparam logic [31:0] DRAG_K     = 32'd6734509;
   localparam logic [41:0] GRAV_Q16   = 42'd642253;
   localparam logic [15:0] MASS_RESET = 16'd51;
   localparam logic [15:0] MASS_ZERO  = 16'd51;
   localparam logic [9:0]  TPS_RESET  = 10'd30;
   localparam logic [9:0]  TPS_ZERO   = 10'd1;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_MASS = 2'd0;
   localparam csr_index_type CSR_TPS  = 2'd1;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_MUL,
      ST_SQ_ACC,
      ST_SQRT_GO,
      ST_SQRT_WAIT,
      ST_K_MUL,
      ST_F_GO,
      ST_F_WAIT,
      ST_A_MLO,
      ST_A_MHI,
      ST_A_ACC,
      ST_A_DIV,
      ST_A_WAIT,
      ST_V_DIV,
      ST_V_WAIT,
      ST_DONE
   } state_type;

   // Command to the shared divider.
   typedef struct packed {
      logic                 start;
      logic [DIV_W-1:0]     dividend;
      logic [15:0]          divisor;
      logic [DIV_CNT_W-1:0] steps;
   } div_cmd_type;

endpackage

[sv/bdes_mul.sv]
// Shared 32 by 32 unsigned multiplier with a registered product.
module bdes_mul (
   input  logic        clock,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [63:0] prod
);
   logic [63:0] prod_ff;

   // The product is registered: it appears in the cycle after the operands.
   always_ff @(posedge clock) begin
      prod_ff <= 64'(op_a) * 64'(op_b);
   end

   assign prod = prod_ff;
endmodule

[sv/bdes_sqrt.sv]
// Bit-serial integer square root, two radicand bits per cycle.
module bdes_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);
   import bdes_pkg::*;

   logic [63:0] rad_ff, rad_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   // One digit of the root per step.
   always_comb begin
      logic [35:0] rem_sh;
      logic [35:0] trial;
      logic        ge;
      rem_sh  = {rem_ff, rad_ff[63:62]};
      trial   = {2'b00, root_ff, 2'b01};
      ge      = rem_sh >= trial;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 5'(SQRT_STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[61:0], 2'b00};
         rem_in  = ge ? 34'(rem_sh - trial) : rem_sh[33:0];
         root_in = {root_ff[30:0], ge};
         cnt_in  = cnt_ff - 5'd1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

[sv/bdes_div.sv]
// Shared restoring divider, one quotient bit per cycle, left-aligned dividend.
module bdes_div (
   input  logic                  clock,
   input  logic                  reset,
   input  bdes_pkg::div_cmd_type cmd,
   output logic                  done,
   output logic [47:0]           quotient
);
   import bdes_pkg::*;

   logic [15:0]          rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [15:0]          dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   // Shift one dividend bit into the partial remainder and try a subtraction.
   always_comb begin
      logic [16:0] rem_sh;
      logic        ge;
      rem_sh  = {rem_ff, quo_ff[DIV_W-1]};
      ge      = rem_sh >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         rem_in  = '0;
         quo_in  = cmd.dividend;
         dvs_in  = cmd.divisor;
         cnt_in  = cmd.steps - 1'b1;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? 16'(rem_sh - {1'b0, dvs_ff}) : rem_sh[15:0];
         quo_in  = {quo_ff[DIV_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

[sv/ballistic_drag_euler_step_unit.sv]
// Projectile step unit: quadratic drag and gravity, semi-implicit Euler update.
// A load gives its result in the cycle after acceptance. A new transaction is taken only when
// the unit is idle again, after the previous result has been accepted.
// A tick works through the squares, the 32-step root and the 48-step drag division,
// then per axis through the 40-step and 32-step divisions by the tick rate.
// Synchronous reset clears the state; mass returns to 0.2 kg and the rate to 30 per second.
module ballistic_drag_euler_step_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_action,
   input  logic signed [39:0]     req_load_pos_x,
   input  logic signed [39:0]     req_load_pos_y,
   input  logic signed [39:0]     req_load_pos_z,
   input  logic signed [31:0]     req_load_vel_x,
   input  logic signed [31:0]     req_load_vel_y,
   input  logic signed [31:0]     req_load_vel_z,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [39:0]     rsp_pos_x,
   output logic signed [39:0]     rsp_pos_y,
   output logic signed [39:0]     rsp_pos_z,
   output logic signed [31:0]     rsp_vel_x,
   output logic signed [31:0]     rsp_vel_y,
   output logic signed [31:0]     rsp_vel_z,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  bdes_pkg::csr_index_type csr_index,
   input  logic [15:0]            csr_data
);
   import bdes_pkg::*;

   state_type state_ff, state_in;

   logic signed [POS_W-1:0] pos_ff [3];
   logic signed [VEL_W-1:0] vel_ff [3];
   logic [1:0]  ax_ff;
   logic [15:0] mass_ff;
   logic [9:0]  tps_ff;
   logic [63:0] s2_ff;
   logic [47:0] f_ff;
   logic [63:0] lo_ff;
   logic [39:0] d_ff;
   logic        neg_ff;

   logic [31:0]  mul_a, mul_b;
   logic [63:0]  prod;
   logic         sqrt_start, sqrt_done;
   logic [31:0]  root;
   div_cmd_type  div_cmd;
   logic         div_done;
   logic [47:0]  quo;

   logic signed [VEL_W-1:0] vcur;
   logic                    vneg;
   logic [31:0]             mag;
   logic [15:0]             m_eff;
   logic [9:0]              t_eff;
   logic [79:0]             sum80;
   logic signed [41:0]      acc_a;
   logic [41:0]             amag;
   logic signed [41:0]      dv, vsum, dp, psum;
   logic signed [VEL_W-1:0] vnew;
   logic signed [POS_W-1:0] pnew;
   logic                    req_acc;

   assign req_acc = req_valid && !req_stall;

   // Operand of the current axis and the effective registers.
   assign vcur  = vel_ff[ax_ff];
   assign vneg  = vcur[VEL_W-1];
   assign mag   = vneg ? 32'(-vcur) : 32'(vcur);
   assign m_eff = (mass_ff == '0) ? MASS_ZERO : mass_ff;
   assign t_eff = (tps_ff == '0) ? TPS_ZERO : tps_ff;

   // Drag term: low and high partial products joined, then scaled down by 2^40.
   assign sum80 = {prod[47:0], 32'b0} + {16'b0, lo_ff};

   // Acceleration of the current axis with gravity on the vertical one.
   always_comb begin
      acc_a = vneg ? $signed({2'b00, d_ff}) : -$signed({2'b00, d_ff});
      if (ax_ff == 2'd1) begin
         acc_a = acc_a - $signed(GRAV_Q16);
      end
      amag = acc_a[41] ? 42'(-acc_a) : 42'(acc_a);
   end

   // Velocity update with saturation.
   always_comb begin
      dv   = neg_ff ? -$signed({2'b00, quo[39:0]}) : $signed({2'b00, quo[39:0]});
      vsum = $signed({{10{vcur[VEL_W-1]}}, vcur}) + dv;
      if (vsum > 42'sd2147483647) begin
         vnew = 32'sh7FFFFFFF;
      end else if (vsum < -42'sd2147483648) begin
         vnew = 32'sh80000000;
      end else begin
         vnew = vsum[31:0];
      end
   end

   // Position update with saturation.
   always_comb begin
      logic signed [POS_W-1:0] pcur;
      pcur = pos_ff[ax_ff];
      dp   = neg_ff ? -$signed({10'b0, quo[31:0]}) : $signed({10'b0, quo[31:0]});
      psum = $signed({{2{pcur[POS_W-1]}}, pcur}) + dp;
      if (psum > 42'sd549755813887) begin
         pnew = 40'sh7FFFFFFFFF;
      end else if (psum < -42'sd549755813888) begin
         pnew = 40'sh8000000000;
      end else begin
         pnew = psum[39:0];
      end
   end

   // Sequencer: next state and unit commands.
   always_comb begin
      state_in         = state_ff;
      mul_a            = '0;
      mul_b            = '0;
      sqrt_start       = 1'b0;
      div_cmd.start    = 1'b0;
      div_cmd.dividend = '0;
      div_cmd.divisor  = {6'b0, t_eff};
      div_cmd.steps    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = req_action ? ST_DONE : ST_SQ_MUL;
            end
         end
         ST_SQ_MUL: begin
            mul_a    = mag;
            mul_b    = mag;
            state_in = ST_SQ_ACC;
         end
         ST_SQ_ACC: begin
            state_in = (ax_ff == 2'd2) ? ST_SQRT_GO : ST_SQ_MUL;
         end
         ST_SQRT_GO: begin
            sqrt_start = 1'b1;
            state_in   = ST_SQRT_WAIT;
         end
         ST_SQRT_WAIT: begin
            if (sqrt_done) begin
               state_in = ST_K_MUL;
            end
         end
         ST_K_MUL: begin
            mul_a    = DRAG_K;
            mul_b    = root;
            state_in = ST_F_GO;
         end
         ST_F_GO: begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = prod[55:8];
            div_cmd.divisor  = m_eff;
            div_cmd.steps    = DIV_CNT_W'(DIV_W);
            state_in         = ST_F_WAIT;
         end
         ST_F_WAIT: begin
            if (div_done) begin
               state_in = ST_A_MLO;
            end
         end
         ST_A_MLO: begin
            mul_a    = mag;
            mul_b    = f_ff[31:0];
            state_in = ST_A_MHI;
         end
         ST_A_MHI: begin
            mul_a    = mag;
            mul_b    = {16'b0, f_ff[47:32]};
            state_in = ST_A_ACC;
         end
         ST_A_ACC: begin
            state_in = ST_A_DIV;
         end
         ST_A_DIV: begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = {amag[39:0], 8'b0};
            div_cmd.steps    = DIV_CNT_W'(40);
            state_in         = ST_A_WAIT;
         end
         ST_A_WAIT: begin
            if (div_done) begin
               state_in = ST_V_DIV;
            end
         end
         ST_V_DIV: begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = {mag, 16'b0};
            div_cmd.steps    = DIV_CNT_W'(VEL_W);
            state_in         = ST_V_WAIT;
         end
         ST_V_WAIT: begin
            if (div_done) begin
               state_in = (ax_ff == 2'd2) ? ST_DONE : ST_A_MLO;
            end
         end
         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff <= MASS_RESET;
         tps_ff  <= TPS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MASS: mass_ff <= csr_data;
            CSR_TPS:  tps_ff  <= csr_data[9:0];
            default:  ;
         endcase
      end
   end

   // Projectile state and working registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
            vel_ff[i] <= '0;
         end
         ax_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               ax_ff <= '0;
               s2_ff <= '0;
               if (req_acc && req_action) begin
                  pos_ff[0] <= req_load_pos_x;
                  pos_ff[1] <= req_load_pos_y;
                  pos_ff[2] <= req_load_pos_z;
                  vel_ff[0] <= req_load_vel_x;
                  vel_ff[1] <= req_load_vel_y;
                  vel_ff[2] <= req_load_vel_z;
               end
            end
            ST_SQ_ACC: begin
               s2_ff <= s2_ff + prod;
               ax_ff <= (ax_ff == 2'd2) ? 2'd0 : ax_ff + 2'd1;
            end
            ST_F_WAIT: begin
               if (div_done) begin
                  f_ff <= quo;
               end
            end
            ST_A_MHI: lo_ff <= prod;
            ST_A_ACC: d_ff  <= sum80[79:40];
            ST_A_DIV: neg_ff <= acc_a[41];
            ST_A_WAIT: begin
               if (div_done) begin
                  vel_ff[ax_ff] <= vnew;
               end
            end
            ST_V_DIV: neg_ff <= vneg;
            ST_V_WAIT: begin
               if (div_done) begin
                  pos_ff[ax_ff] <= pnew;
                  ax_ff         <= (ax_ff == 2'd2) ? 2'd0 : ax_ff + 2'd1;
               end
            end
            default: ;
         endcase
      end
   end

   bdes_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   bdes_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (s2_ff),
      .done     (sqrt_done),
      .root     (root)
   );

   bdes_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .done     (div_done),
      .quotient (quo)
   );

   // Handshakes and result transaction.
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_pos_x = pos_ff[0];
   assign rsp_pos_y = pos_ff[1];
   assign rsp_pos_z = pos_ff[2];
   assign rsp_vel_x = vel_ff[0];
   assign rsp_vel_y = vel_ff[1];
   assign rsp_vel_z = vel_ff[2];
endmodule

[sv/bdes_checker.sv]
// Port-level checks of the projectile step unit and their binding.
module bdes_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_action,
   input logic signed [39:0] req_load_pos_x,
   input logic signed [31:0] req_load_vel_z,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [39:0] rsp_pos_x,
   input logic signed [39:0] rsp_pos_y,
   input logic signed [31:0] rsp_vel_y,
   input logic signed [31:0] rsp_vel_z
);
`include "ballistic_drag_euler_step_unit_defines.svh"

   // A stalled result transaction stays offered.
   `BDES_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")

   // A stalled result keeps its y position and y velocity.
   `BDES_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_pos_y) && $stable(rsp_vel_y), "result changed while stalled")

   // No new transaction is taken while a result waits.
   `BDES_ASSERT_IMP(a_one_at_a_time, clock, reset, rsp_valid, req_stall, "input open while result pending")

   // A load is echoed on the next cycle, checked on its x position and z velocity.
   `BDES_ASSERT_NXT(a_load_echo, clock, reset, req_valid && !req_stall && req_action, rsp_valid && rsp_pos_x == $past(req_load_pos_x) && rsp_vel_z == $past(req_load_vel_z), "load not returned")

endmodule

bind ballistic_drag_euler_step_unit bdes_checker u_bdes_checker (.*);

[sim/tb_ballistic_drag_euler_step_unit.sv]
// Testbench for the projectile step unit: directed and random load and tick traffic checked against a predictor.
`timescale 1ns / 1ps

module tb_ballistic_drag_euler_step_unit;
   import bdes_pkg::*;

   localparam int CLK_HI    = 6;
   localparam int CLK_LO    = 6;
   localparam int RST_CYC   = 7;
   localparam int TICK_LAT  = 400;
   localparam longint CYCLE_LIMIT = 3000000;

   localparam logic ACT_TICK = 1'b0;
   localparam logic ACT_LOAD = 1'b1;

   // A register index that selects no register.
   localparam csr_index_type CSR_UNUSED = 2'd3;

   localparam longint POS_MAX = 64'sd549755813887;
   localparam longint POS_MIN = -64'sd549755813888;
   localparam longint VEL_MAX = 64'sd2147483647;
   localparam longint VEL_MIN = -64'sd2147483648;

   typedef struct packed {
      logic              action;
      logic signed [39:0] px, py, pz;
      logic signed [31:0] vx, vy, vz;
   } step_req_type;

   typedef struct packed {
      logic signed [39:0] px, py, pz;
      logic signed [31:0] vx, vy, vz;
   } kin_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_action = 1'b0;
   logic signed [39:0] req_load_pos_x = '0, req_load_pos_y = '0, req_load_pos_z = '0;
   logic signed [31:0] req_load_vel_x = '0, req_load_vel_y = '0, req_load_vel_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [39:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [31:0] rsp_vel_x, rsp_vel_y, rsp_vel_z;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_MASS;
   logic [15:0] csr_data = '0;

   ballistic_drag_euler_step_unit u_dut (.*);

   // Clock generation.
   always begin
      #CLK_HI clock = 1'b1;
      #CLK_LO clock = 1'b0;
   end

   step_req_type  pending_reqs[$];
   kin_state_type expected_kin[$];
   kin_state_type kin;
   logic [15:0] mass_reg;
   logic [9:0]  tps_reg;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int errors = 0;
   longint cycles = 0;

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint abs64(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] n);
      logic [63:0] rem, root, bitv;
      rem = n; root = 0; bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem  = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // Append a transaction to the stimulus queue.
   function automatic void add_req(step_req_type r);
      pending_reqs.insert(pending_reqs.size(), r);
   endfunction

   // Advance the predicted projectile by one transaction.
   function automatic void advance_kin(step_req_type r);
      logic [63:0] mag[3];
      logic [63:0] s2, spd, fac, m;
      logic [127:0] prod;
      longint vel[3], pos[3], t, d, a;
      if (r.action == ACT_LOAD) begin
         kin = '{r.px, r.py, r.pz, r.vx, r.vy, r.vz};
         return;
      end
      vel = '{longint'(kin.vx), longint'(kin.vy), longint'(kin.vz)};
      pos = '{longint'(kin.px), longint'(kin.py), longint'(kin.pz)};
      m = (mass_reg != 0) ? 64'(mass_reg) : 64'd51;
      t = (tps_reg != 0) ? longint'(tps_reg) : 1;
      s2 = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = 64'(abs64(vel[i]));
         s2 = s2 + mag[i] * mag[i];
      end
      spd = int_sqrt(s2);
      fac = (64'd6734509 * spd) / (m * 256);
      for (int i = 0; i < 3; i++) begin
         prod = 128'(mag[i]) * 128'(fac);
         d = longint'(prod >> 40);
         a = vel[i] < 0 ? d : -d;
         if (i == 1) a = a - 642253;
         vel[i] = clip(vel[i] + a / t, VEL_MIN, VEL_MAX);
         pos[i] = clip(pos[i] + vel[i] / t, POS_MIN, POS_MAX);
      end
      kin = '{40'(pos[0]), 40'(pos[1]), 40'(pos[2]),
              32'(vel[0]), 32'(vel[1]), 32'(vel[2])};
   endfunction

   // Driver: presents queued transactions, idling at random, and stalls results at random.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               step_req_type r;
               r = pending_reqs.pop_front();
               advance_kin(r);
               expected_kin.insert(expected_kin.size(), kin);
               req_valid      <= 1'b1;
               req_action     <= r.action;
               req_load_pos_x <= r.px;
               req_load_pos_y <= r.py;
               req_load_pos_z <= r.pz;
               req_load_vel_x <= r.vx;
               req_load_vel_y <= r.vy;
               req_load_vel_z <= r.vz;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99, 0) < recv_idle_pct);
      end
   end

   // Monitor: checks each accepted result against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         kin_state_type got, want;
         got = '{rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_vel_x, rsp_vel_y, rsp_vel_z};
         if (expected_kin.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors = errors + 1;
         end else begin
            want = expected_kin.pop_front();
            if (got.px !== want.px) begin
               $display("%0t: pos_x expected %0d actual %0d", $time, want.px, got.px);
               errors = errors + 1;
            end
            if (got.py !== want.py) begin
               $display("%0t: pos_y expected %0d actual %0d", $time, want.py, got.py);
               errors = errors + 1;
            end
            if (got.pz !== want.pz) begin
               $display("%0t: pos_z expected %0d actual %0d", $time, want.pz, got.pz);
               errors = errors + 1;
            end
            if (got.vx !== want.vx) begin
               $display("%0t: vel_x expected %0d actual %0d", $time, want.vx, got.vx);
               errors = errors + 1;
            end
            if (got.vy !== want.vy) begin
               $display("%0t: vel_y expected %0d actual %0d", $time, want.vy, got.vy);
               errors = errors + 1;
            end
            if (got.vz !== want.vz) begin
               $display("%0t: vel_z expected %0d actual %0d", $time, want.vz, got.vz);
               errors = errors + 1;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic step_req_type mk_load(longint px, longint py, longint pz,
                                            longint vx, longint vy, longint vz);
      step_req_type r;
      r.action = ACT_LOAD;
      r.px = 40'(px); r.py = 40'(py); r.pz = 40'(pz);
      r.vx = 32'(vx); r.vy = 32'(vy); r.vz = 32'(vz);
      return r;
   endfunction

   function automatic step_req_type mk_tick();
      step_req_type r;
      r = '0;
      r.action = ACT_TICK;
      // Some load fields carry junk on a tick; they must be ignored.
      r.px = 40'({$urandom, $urandom}); r.vx = $urandom; r.vz = $urandom;
      return r;
   endfunction

   function automatic logic [39:0] rnd_pos(int shift);
      logic [39:0] v;
      v = 40'({$urandom, $urandom});
      return 40'($signed(v) >>> shift);
   endfunction

   function automatic logic [31:0] rnd_vel();
      logic [31:0] v;
      v = $urandom;
      // Mostly plausible projectile speeds, sometimes the full range.
      return ($urandom_range(3, 0) == 0) ? v : 32'($signed(v) >>> $urandom_range(14, 4));
   endfunction

   task automatic drain();
      while (pending_reqs.size() != 0 || expected_kin.size() != 0) @(posedge clock);
      repeat (TICK_LAT) @(posedge clock);
   endtask

   // Register write while the unit is idle.
   task automatic csr_write(csr_index_type idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_MASS) mass_reg = val;
      else if (idx == CSR_TPS) tps_reg = val[9:0];
   endtask

   task automatic random_burst(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9, 0) == 0) begin
            add_req(mk_load(longint'($signed(rnd_pos($urandom_range(20, 0)))),
               longint'($signed(rnd_pos($urandom_range(20, 0)))),
               longint'($signed(rnd_pos($urandom_range(20, 0)))),
               longint'($signed(rnd_vel())), longint'($signed(rnd_vel())),
               longint'($signed(rnd_vel()))));
         end else begin
            add_req(mk_tick());
         end
      end
   endtask

   // Stimulus sequence.
   initial begin
      logic [15:0] masses[6];
      logic [9:0]  rates[6];
      kin = '0;
      mass_reg = 16'd51;
      tps_reg = 10'd30;
      masses = '{16'd51, 16'd0, 16'd1, 16'hFFFF, 16'd256, 16'd3000};
      rates  = '{10'd30, 10'd1, 10'd1000, 10'd0, 10'd1023, 10'd60};
      repeat (RST_CYC) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset state, field extremes, zero speed, saturation.
      add_req(mk_tick());
      add_req(mk_load(POS_MAX, POS_MIN, 0, VEL_MAX, VEL_MIN, 0));
      add_req(mk_tick());
      add_req(mk_tick());
      add_req(mk_load(POS_MIN, POS_MIN, POS_MAX, VEL_MIN, VEL_MIN, VEL_MIN));
      add_req(mk_tick());
      add_req(mk_load(0, 0, 0, 0, 0, 0));
      add_req(mk_tick());
      add_req(mk_load(-1, -1, -1, -1, -1, -1));
      add_req(mk_tick());
      add_req(mk_load(12345 << 16, 100 << 16, -5 << 16,
                      800 << 16, 300 << 16, -50 << 16));
      add_req(mk_tick());
      add_req(mk_tick());
      add_req(mk_load(POS_MAX, POS_MAX, POS_MAX, VEL_MAX, VEL_MAX, VEL_MAX));
      add_req(mk_tick());
      drain();

      // Random phases through register settings and idling patterns.
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(CSR_MASS, masses[ph]);
         csr_write(CSR_TPS, {6'($urandom), rates[ph]});
         if (ph < 2) begin
            send_idle_pct = 10; recv_idle_pct = 57;
         end else if (ph < 4) begin
            send_idle_pct = 57; recv_idle_pct = 10;
         end else begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         pending_pos_seed: begin
            add_req(mk_load(longint'($signed(rnd_pos(8))),
               longint'($signed(rnd_pos(12))), longint'($signed(rnd_pos(8))),
               longint'($signed(rnd_vel())), longint'($signed(rnd_vel())),
               longint'($signed(rnd_vel()))));
         end
         random_burst(330);
         drain();
      end
      // Out-of-range register index must be ignored.
      csr_write(CSR_UNUSED, 16'h1234);
      add_req(mk_tick());
      drain();

      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
